FILE: rtl/scp_pkg.sv
// Package for the CAN signal packer with slcan line output.
// Holds the request and result types, control structs, character codes and helpers.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package scp_pkg;

  // One signal request.
  typedef struct packed {
    logic [63:0] signal_value;
    logic [5:0]  start_bit;
    logic [6:0]  bit_length;
    logic        byte_order;
    logic        signal_valid;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic        last_signal;
  } scp_in_t;

  // One character of the slcan line.
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } scp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       pack;
    logic       load;
    logic [4:0] char_idx;
  } scp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic line_done;
  } scp_sts_t;

  // Byte order codes.
  localparam logic ORDER_MOTOROLA = 1'b0;
  localparam logic ORDER_INTEL    = 1'b1;

  // Fixed characters of the line.
  localparam logic [7:0] CHAR_FRAME_T = 8'h74;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  // Positions within the line.
  localparam logic [4:0] IDX_CMD    = 5'd0;
  localparam logic [4:0] IDX_ID_HI  = 5'd1;
  localparam logic [4:0] IDX_ID_MID = 5'd2;
  localparam logic [4:0] IDX_ID_LO  = 5'd3;
  localparam logic [4:0] IDX_DLC    = 5'd4;
  localparam logic [4:0] IDX_DATA   = 5'd5;

  localparam logic [6:0] MAX_LEN   = 7'd64;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  // Uppercase hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  // Full 64-bit reversal.
  function automatic logic [63:0] bit_rev64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = v[63 - i];
    end
    return r;
  endfunction

  // Reversal of the bits inside each byte, bytes stay in place.
  function automatic logic [63:0] bit_rev_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < 8; i++) begin
        r[b * 8 + i] = v[b * 8 + 7 - i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/scp_stream_if.sv
// Valid/ready channels for signal requests and output characters.
// Depends on scp_pkg for the payload types.
`default_nettype none

interface scp_in_if;
  logic              valid;
  logic              ready;
  scp_pkg::scp_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scp_out_if;
  logic              valid;
  logic              ready;
  scp_pkg::scp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/scp_ctrl.sv
// Controller of the signal packer: sequences capture, packing and line output.
// Depends on scp_pkg for the command and status structs.
`default_nettype none

module scp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire scp_pkg::scp_sts_t sts_i,
  output scp_pkg::scp_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PACK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [4:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic       load;

  // A character enters the output register when it is empty or being taken.
  assign load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Next state, character index and output valid.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PACK;
        end
      end
      ST_PACK: begin
        idx_d = scp_pkg::IDX_CMD;
        state_d = sts_i.frame_end ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (load) begin
          idx_d = idx_q + 5'd1;
          if (sts_i.line_done) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.pack     = (state_q == ST_PACK);
    cmd_o.load     = load;
    cmd_o.char_idx = idx_q;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/scp_datapath.sv
// Datapath of the signal packer: request register, payload word and character register.
// Depends on scp_pkg for types, character codes and bit-order helpers.
`default_nettype none

module scp_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scp_pkg::scp_in_t  in_data_i,
  input  wire scp_pkg::scp_cmd_t cmd_i,
  output scp_pkg::scp_sts_t      sts_o,
  output scp_pkg::scp_out_t      out_data_o
);

  scp_pkg::scp_in_t req_q;
  logic [63:0]      payload_q, payload_d;
  logic [7:0]       char_q, char_d;
  logic             last_q;

  logic [6:0]  len_eff;
  logic [63:0] mask;
  logic [63:0] value_m;
  logic [5:0]  moto_start;
  logic [63:0] moto_w;
  logic [63:0] contrib;
  logic [3:0]  nbytes;
  logic [4:0]  last_idx;
  logic [4:0]  data_j;
  logic [3:0]  nib_sel;
  logic [3:0]  data_nib;
  logic        is_cr;

  // Request register, loaded at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
  end

  // Length clamped to 64 and the value masked to it.
  always_comb begin
    len_eff = (req_q.bit_length > scp_pkg::MAX_LEN) ? scp_pkg::MAX_LEN : req_q.bit_length;
    if (len_eff == scp_pkg::MAX_LEN) begin
      mask = '1;
    end else begin
      mask = (64'd1 << len_eff[5:0]) - 64'd1;
    end
    value_m = req_q.signal_value & mask;
  end

  // Motorola order runs upward in a sawtooth numbering where each byte is
  // reversed, so the reversed value is aligned there and mapped back.
  always_comb begin
    moto_start = {req_q.start_bit[5:3], ~req_q.start_bit[2:0]};
    moto_w     = (scp_pkg::bit_rev64(value_m) >> (scp_pkg::MAX_LEN - len_eff)) << moto_start;
    if (!req_q.signal_valid || (len_eff == 7'd0)) begin
      contrib = '0;
    end else if (req_q.byte_order == scp_pkg::ORDER_INTEL) begin
      contrib = value_m << req_q.start_bit;
    end else begin
      contrib = scp_pkg::bit_rev_bytes(moto_w);
    end
  end

  // Character selection for the current line position.
  always_comb begin
    nbytes   = (req_q.frame_len > scp_pkg::MAX_BYTES) ? scp_pkg::MAX_BYTES : req_q.frame_len;
    last_idx = scp_pkg::IDX_DATA + {nbytes, 1'b0};
    data_j   = cmd_i.char_idx - scp_pkg::IDX_DATA;
    nib_sel  = {data_j[3:1], ~data_j[0]};
    data_nib = payload_q[{nib_sel, 2'b00} +: 4];
    is_cr    = (cmd_i.char_idx == last_idx);
    priority if (cmd_i.char_idx == scp_pkg::IDX_CMD) begin
      char_d = scp_pkg::CHAR_FRAME_T;
    end else if (cmd_i.char_idx == scp_pkg::IDX_ID_HI) begin
      char_d = scp_pkg::hex_char({1'b0, req_q.frame_id[10:8]});
    end else if (cmd_i.char_idx == scp_pkg::IDX_ID_MID) begin
      char_d = scp_pkg::hex_char(req_q.frame_id[7:4]);
    end else if (cmd_i.char_idx == scp_pkg::IDX_ID_LO) begin
      char_d = scp_pkg::hex_char(req_q.frame_id[3:0]);
    end else if (cmd_i.char_idx == scp_pkg::IDX_DLC) begin
      char_d = scp_pkg::hex_char(req_q.frame_len);
    end else if (is_cr) begin
      char_d = scp_pkg::CHAR_CR;
    end else begin
      char_d = scp_pkg::hex_char(data_nib);
    end
  end

  // Payload word: ORed on packing, cleared once the closing character is loaded.
  always_comb begin
    payload_d = payload_q;
    if (cmd_i.load && is_cr) begin
      payload_d = '0;
    end else if (cmd_i.pack) begin
      payload_d = payload_q | contrib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= '0;
    end else begin
      payload_q <= payload_d;
    end
  end

  // Output character register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= char_d;
      last_q <= is_cr;
    end
  end

  assign sts_o.frame_end       = req_q.last_signal;
  assign sts_o.line_done       = is_cr;
  assign out_data_o.ascii_char = char_q;
  assign out_data_o.last_char  = last_q;

endmodule

`default_nettype wire

FILE: rtl/can_signal_pack_slcan_encode.sv
// Top level of the CAN signal packer with slcan line output.
// Depends on scp_pkg, scp_stream_if, scp_ctrl and scp_datapath.
`default_nettype none

// Each accepted request ORs one signal (Intel or Motorola order, masked to its
// length, bits past payload bit 63 dropped) into a 64-bit payload word. The
// request is registered, then packed. A request with last_signal set then
// emits the slcan line 't', three ID digits, the length digit,
// 2*min(frame_len,8) data digits and a carriage return, one character per
// cycle from the output register, stretched by any backpressure on the
// output. The payload is cleared as the carriage return is loaded, and a new
// request is taken while that character still waits.
module can_signal_pack_slcan_encode (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scp_in_if.sink    in_i,
  scp_out_if.source out_o
);

  scp_pkg::scp_cmd_t cmd;
  scp_pkg::scp_sts_t sts;

  scp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

endmodule

`default_nettype wire

FILE: rtl/scp_checker.sv
// Port-level checks for the CAN signal packer, bound to its top level.
// Depends on scp_pkg for the character codes and on the top level's interface ports.
`default_nettype none

module scp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] ascii_char_i,
  input wire logic       last_char_i
);

  // A stalled character holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ascii_char_i) && $stable(last_char_i))
    else $error("stalled character changed");

  // Each request is packed before the next is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken back to back");

  // No request is taken while a line is still being produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_char_i |-> !in_ready_i)
    else $error("request taken in the middle of a line");

  // The closing character is a carriage return. The next line may follow it
  // at once, since a new request is taken while it still waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_char_i |-> ascii_char_i == scp_pkg::CHAR_CR)
    else $error("bad line end");

endmodule

bind can_signal_pack_slcan_encode scp_checker u_scp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .ascii_char_i (out_o.data.ascii_char),
  .last_char_i  (out_o.data.last_char)
);

`default_nettype wire

FILE: verif/scp_line_checker.sv
// Checker for the CAN signal packer: watches both channels, predicts each slcan line and compares.
// Depends on scp_pkg for the payload types and character codes, and on scp_stream_if.
`default_nettype none

module scp_line_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scp_in_if         in_mon_i,
  scp_out_if        out_mon_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 20;

  logic [63:0]       payload_word;
  scp_pkg::scp_out_t line_q[$];
  scp_pkg::scp_out_t want;
  scp_pkg::scp_in_t  req;
  int                fail_count = 0;
  int                pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // Counts a mismatch; only the first few are printed to keep the log short.
  task automatic report_mismatch(input string what, input logic [7:0] got_c,
                                 input logic [7:0] exp_c);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s mismatch, got %02h expected %02h", $time, what, got_c, exp_c);
    end
  endtask

  // ASCII hex digit of a nibble, capitals for ten and above.
  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'("0") + {4'd0, nib};
    end
    return 8'("A") + {4'd0, nib} - 8'd10;
  endfunction

  // ORs one signal into the payload word, masked to its length.
  function automatic logic [63:0] pack_into_word(input logic [63:0] word,
                                                 input scp_pkg::scp_in_t s);
    int          len;
    int          byte_pos;
    int          bit_pos;
    logic [63:0] v;
    len = int'(s.bit_length);
    if (len == 0) begin
      return word;
    end
    if (len > 64) begin
      len = 64;
    end
    v = s.signal_value;
    if (len < 64) begin
      v &= (64'd1 << len) - 64'd1;
    end
    if (s.byte_order == scp_pkg::ORDER_INTEL) begin
      return word | (v << s.start_bit);
    end
    // Motorola: MSB at the start bit, walking down a byte then into the next byte's bit 7.
    byte_pos = int'(s.start_bit) / 8;
    bit_pos  = int'(s.start_bit) % 8;
    for (int k = 0; k < len; k++) begin
      if (byte_pos < 8) begin
        word[byte_pos * 8 + bit_pos] = word[byte_pos * 8 + bit_pos] | v[len - 1 - k];
      end
      if (bit_pos == 0) begin
        bit_pos = 7;
        byte_pos++;
      end else begin
        bit_pos--;
      end
    end
    return word;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic last);
    scp_pkg::scp_out_t ch;
    ch.ascii_char = c;
    ch.last_char  = last;
    line_q.push_back(ch);
  endfunction

  // Queues the characters of one slcan line for the given frame end.
  function automatic void queue_line(input scp_pkg::scp_in_t s, input logic [63:0] word);
    int         nbytes;
    logic [7:0] data_byte;
    push_char(scp_pkg::CHAR_FRAME_T, 1'b0);
    push_char(nibble_ascii({1'b0, s.frame_id[10:8]}), 1'b0);
    push_char(nibble_ascii(s.frame_id[7:4]), 1'b0);
    push_char(nibble_ascii(s.frame_id[3:0]), 1'b0);
    push_char(nibble_ascii(s.frame_len), 1'b0);
    nbytes = (s.frame_len > scp_pkg::MAX_BYTES) ? int'(scp_pkg::MAX_BYTES)
                                                : int'(s.frame_len);
    for (int i = 0; i < nbytes; i++) begin
      data_byte = word[i * 8 +: 8];
      push_char(nibble_ascii(data_byte[7:4]), 1'b0);
      push_char(nibble_ascii(data_byte[3:0]), 1'b0);
    end
    push_char(scp_pkg::CHAR_CR, 1'b1);
  endfunction

  // Characters are checked before the new request is folded in, since no
  // request can produce a character at the edge where it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_word = '0;
      line_q.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (line_q.size() == 0) begin
          report_mismatch("unexpected character", out_mon_i.data.ascii_char, 8'h00);
        end else begin
          want = line_q.pop_front();
          if (out_mon_i.data.ascii_char !== want.ascii_char) begin
            report_mismatch("ascii_char", out_mon_i.data.ascii_char, want.ascii_char);
          end
          if (out_mon_i.data.last_char !== want.last_char) begin
            report_mismatch("last_char", {7'd0, out_mon_i.data.last_char},
                            {7'd0, want.last_char});
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        req = in_mon_i.data;
        if (req.signal_valid) begin
          payload_word = pack_into_word(payload_word, req);
        end
        if (req.last_signal) begin
          queue_line(req, payload_word);
          payload_word = '0;
        end
      end
    end
    pending = line_q.size();
  end

endmodule

`default_nettype wire

FILE: verif/tb_can_signal_pack_slcan_encode.sv
// Testbench top for the CAN signal packer: clock, reset, request stimulus and output backpressure.
// Depends on scp_pkg, scp_stream_if, the block itself and scp_line_checker.
`default_nettype none

module tb_can_signal_pack_slcan_encode;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  localparam int ITEM_TARGET  = 310;
  localparam int QUIET_TAIL   = 50;
  localparam int LONG_HOLD    = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic MOTO  = scp_pkg::ORDER_MOTOROLA;
  localparam logic INTEL = scp_pkg::ORDER_INTEL;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_chars;
  bit   steady_phase  = 1'b0;
  bit   long_hold_req = 1'b0;

  scp_in_if  in_ch ();
  scp_out_if out_ch ();

  can_signal_pack_slcan_encode dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  scp_line_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_chars)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic scp_pkg::scp_in_t make_signal(input logic [63:0] value,
                                                   input logic [5:0] start,
                                                   input logic [6:0] len, input logic order,
                                                   input logic valid, input logic [10:0] id,
                                                   input logic [3:0] flen, input logic last);
    scp_pkg::scp_in_t s;
    s.signal_value = value;
    s.start_bit    = start;
    s.bit_length   = len;
    s.byte_order   = order;
    s.signal_valid = valid;
    s.frame_id     = id;
    s.frame_len    = flen;
    s.last_signal  = last;
    return s;
  endfunction

  // Random signal; lengths lean to the legal range with some zero and overlong ones.
  function automatic scp_pkg::scp_in_t random_signal(input logic last);
    scp_pkg::scp_in_t s;
    int               pick;
    pick = $urandom_range(0, 19);
    s.signal_value = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      s.signal_value = '1;
    end
    if (pick == 0) begin
      s.bit_length = 7'd0;
    end else if (pick == 1) begin
      s.bit_length = 7'($urandom_range(65, 127));
    end else if (pick < 4) begin
      s.bit_length = scp_pkg::MAX_LEN;
    end else begin
      s.bit_length = 7'($urandom_range(1, 64));
    end
    s.start_bit    = 6'($urandom_range(0, 63));
    s.byte_order   = ($urandom_range(0, 1) != 0) ? INTEL : MOTO;
    s.signal_valid = ($urandom_range(0, 9) != 0);
    s.frame_id     = 11'($urandom_range(0, 2047));
    s.frame_len    = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
    s.last_signal  = last;
    return s;
  endfunction

  // Offers one request, waits for acceptance, then sometimes idles for a short burst.
  task automatic offer_signal(input scp_pkg::scp_in_t s);
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    if (!steady_phase && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Output backpressure: short random stalls, one long hold on request, none at the end.
  initial begin : char_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL can_signal_pack_slcan_encode");
    $finish;
  end

  // Reset, directed frames, random frames, drain and verdict.
  initial begin : stimulus
    int sent;
    int frame_no;
    int n_sig;
    sent     = 0;
    frame_no = 0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Intel extremes: full word, then only the top bit.
    offer_signal(make_signal('1, 6'd0, 7'd64, INTEL, 1'b1, 11'h7FF, 4'd8, 1'b1));
    offer_signal(make_signal('1, 6'd63, 7'd64, INTEL, 1'b1, 11'h555, 4'd8, 1'b1));
    // Motorola within a byte, across a byte boundary, and running off the end.
    offer_signal(make_signal(64'hA5, 6'd7, 7'd8, MOTO, 1'b1, 11'h000, 4'd0, 1'b0));
    offer_signal(make_signal(64'h3, 6'd0, 7'd2, MOTO, 1'b1, 11'h000, 4'd0, 1'b0));
    offer_signal(make_signal(64'hDEADBEEF_01234567, 6'd63, 7'd64, MOTO, 1'b1,
                             11'h2AA, 4'd8, 1'b1));
    // Zero length packs nothing.
    offer_signal(make_signal('1, 6'd0, 7'd0, INTEL, 1'b1, 11'h100, 4'd8, 1'b1));
    // Overlong lengths behave as 64, in both orders; oversized frame length.
    offer_signal(make_signal('1, 6'd7, 7'd127, MOTO, 1'b1, 11'h0FF, 4'd8, 1'b1));
    offer_signal(make_signal('1, 6'd0, 7'd65, INTEL, 1'b1, 11'h0F0, 4'd15, 1'b1));
    // An invalid signal still closes the frame.
    offer_signal(make_signal('1, 6'd0, 7'd64, INTEL, 1'b0, 11'h00F, 4'd9, 1'b1));
    // Empty data field.
    offer_signal(make_signal(64'd0, 6'd0, 7'd1, INTEL, 1'b1, 11'h123, 4'd0, 1'b1));
    // Intel bits past bit 63 are dropped; value masked to a short length.
    offer_signal(make_signal(64'hFF, 6'd60, 7'd8, INTEL, 1'b1, 11'h7FF, 4'd8, 1'b0));
    offer_signal(make_signal('1, 6'd8, 7'd4, INTEL, 1'b1, 11'h456, 4'd12, 1'b1));
    // Motorola starting at the bottom of the last byte and of the first byte.
    offer_signal(make_signal('1, 6'd56, 7'd64, MOTO, 1'b1, 11'h789, 4'd8, 1'b1));
    offer_signal(make_signal('1, 6'd0, 7'd64, MOTO, 1'b1, 11'h3BC, 4'd4, 1'b1));
    sent = 14;

    // Random frames of a few signals each, closed by a frame end.
    while (sent < ITEM_TARGET) begin
      if (sent > ITEM_TARGET - QUIET_TAIL) begin
        steady_phase = 1'b1;
      end
      // Long output hold while requests keep coming, so the block backs up.
      if (frame_no == 8) begin
        long_hold_req = 1'b1;
      end
      // Pause until every queued character has been delivered.
      if (frame_no == 20) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        wait (pending_chars == 0);
        @(posedge clk_i);
      end
      n_sig = $urandom_range(0, 5);
      for (int i = 0; i < n_sig; i++) begin
        offer_signal(random_signal(1'b0));
        sent++;
      end
      offer_signal(random_signal(1'b1));
      sent++;
      frame_no++;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_chars == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("PASS can_signal_pack_slcan_encode");
    end else begin
      $display("FAIL can_signal_pack_slcan_encode");
    end
    $finish;
  end

endmodule

`default_nettype wire
